/* design/scq_pkg.sv */
// Shared types and codes for the smallest covering interval query block.
// No dependencies.
package scq_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_INVALID = 2'd2
  } stat_e;

  localparam int unsigned PointW = 32;
  localparam int unsigned LenW   = PointW + 1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PointW-1:0] left_end;
    logic [PointW-1:0] right_end;
    logic [PointW-1:0] query_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic [LenW-1:0] min_length;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_out;
  } scq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic out_free;
  } scq_sts_t;

endpackage

/* design/scq_ctrl.sv */
// Sequencer for the interval query block: accept, table scan, result post.
// Depends on scq_pkg.
module scq_ctrl
  import scq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  scq_sts_t sts,
  output scq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_POST  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = sts.start_scan ? S_SCAN : S_POST;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_POST;
      end
      S_POST: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/scq_datapath.sv */
// Interval table memory, fill count, scan compare/min unit and result register.
// Depends on scq_pkg; driven by scq_ctrl commands.
module scq_datapath
  import scq_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  scq_cmd_t  cmd,
  output scq_sts_t  sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  logic [2*PointW-1:0] mem [MAX_INTERVALS];

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       scan_idx_r;
  logic [PointW-1:0]   pt_r;
  logic [2*PointW-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [1:0]          status_r;
  logic                found_r;
  logic [LenW-1:0]     best_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic              is_full;
  logic              bad_order;
  logic              do_write;
  logic [PointW-1:0] ent_lo;
  logic [PointW-1:0] ent_hi;
  logic              hit;
  logic [LenW-1:0]   ent_len;
  logic              take;

  assign is_full   = (count_r == CW'(MAX_INTERVALS));
  assign bad_order = (in_item.left_end > in_item.right_end);
  assign do_write  = cmd.accept && (in_item.mode == MODE_ADD) && !bad_order && !is_full;

  assign ent_lo  = rd_data_r[2*PointW-1:PointW];
  assign ent_hi  = rd_data_r[PointW-1:0];
  assign hit     = rd_vld_r && (ent_lo <= pt_r) && (pt_r <= ent_hi);
  assign ent_len = {1'b0, ent_hi} - {1'b0, ent_lo} + LenW'(1);
  assign take    = hit && (!found_r || (ent_len < best_r));

  assign sts.start_scan = (in_item.mode == MODE_QUERY) && (count_r != '0);
  assign sts.scan_last  = (scan_idx_r == count_r - CW'(1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count_r[AW-1:0]] <= {in_item.left_end, in_item.right_end};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[scan_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.accept && (in_item.mode == MODE_CLEAR)) begin
        count_r <= '0;
      end else if (do_write) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt_r       <= in_item.query_point;
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      best_r     <= '0;
      status_r   <= STAT_OK;
      if (in_item.mode == MODE_ADD) begin
        if (bad_order) begin
          status_r <= STAT_INVALID;
        end else if (is_full) begin
          status_r <= STAT_FULL;
        end
      end
    end else begin
      if (cmd.rd_en) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
      if (take) begin
        found_r <= 1'b1;
        best_r  <= ent_len;
      end
    end
    if (cmd.load_out) begin
      out_item_r.status     <= status_r;
      out_item_r.found      <= found_r;
      out_item_r.min_length <= best_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* design/smallest_covering_interval_query.sv */
// Top level of the smallest covering interval query block.
// Depends on scq_pkg, scq_ctrl and scq_datapath.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_item  (in_item_t)
//   out_     output     out_valid / out_stall  out_item (out_item_t)
//
// A clear, an add or a query on an empty table goes from accept straight to the result
// post; a query with stored entries first scans the table, reading one entry per cycle,
// then the last read drains through the read register before the result is posted.
// Reset clears the entry count, the controller and the output valid; the
// table itself is not cleared. One item is in work at a time; a finished
// result waits in the output register while out_stall is high, and the
// next item is accepted meanwhile.
module smallest_covering_interval_query
  import scq_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  scq_cmd_t cmd;
  scq_sts_t sts;

  scq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scq_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("pending result overwritten");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  a_scan_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (in_stall && !cmd.accept))
    else $error("table read outside a query scan");

endmodule

/* verif/scq_cover_checker.sv */
`timescale 1ns / 1ps
// Checker for smallest_covering_interval_query: keeps its own interval table, predicts
// one result per accepted input transfer and compares every accepted output transfer.
// Depends on scq_pkg.
module scq_cover_checker
  import scq_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic [PointW-1:0] left_ends  [MAX_INTERVALS];
  logic [PointW-1:0] right_ends [MAX_INTERVALS];
  int unsigned       stored = 0;
  out_item_t         cover_q [$];
  out_item_t         want;
  int                errs = 0;

  function automatic out_item_t cover_step(input in_item_t it);
    out_item_t       r;
    logic [LenW-1:0] span;
    int unsigned     i;
    r = '0;
    case (it.mode)
      MODE_CLEAR: stored = 0;
      MODE_ADD: begin
        if (it.left_end > it.right_end) begin
          r.status = STAT_INVALID;
        end else if (stored >= MAX_INTERVALS) begin
          r.status = STAT_FULL;
        end else begin
          left_ends[stored]  = it.left_end;
          right_ends[stored] = it.right_end;
          stored++;
        end
      end
      MODE_QUERY: begin
        for (i = 0; i < stored; i++) begin
          if (left_ends[i] <= it.query_point && it.query_point <= right_ends[i]) begin
            span = {1'b0, right_ends[i]} - {1'b0, left_ends[i]} + 1'b1;
            if (!r.found || span < r.min_length) begin
              r.found      = 1'b1;
              r.min_length = span;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cover_q.delete();
      stored = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cover_q.size() == 0) begin
          $error("unexpected result: status %0d found %0d min_length %0d",
                 out_item.status, out_item.found, out_item.min_length);
          errs++;
        end else begin
          want = cover_q.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            errs++;
          end
          if (out_item.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_item.found);
            errs++;
          end
          if (out_item.min_length !== want.min_length) begin
            $error("min_length: expected %0d, actual %0d",
                   want.min_length, out_item.min_length);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        cover_q.push_back(cover_step(in_item));
      end
    end
    pending    <= cover_q.size();
    fail_count <= errs;
  end

endmodule

/* verif/smallest_covering_interval_query_tb.sv */
`timescale 1ns / 1ps
// Testbench top for smallest_covering_interval_query: drives clears, interval adds and
// point queries and spare modes, idles both channels at random and prints the verdict.
// Depends on scq_pkg, the block under test and scq_cover_checker.
module smallest_covering_interval_query_tb;
  import scq_pkg::*;

  localparam int unsigned MAX_INTERVALS = 64;
  localparam int          ITEM_GOAL     = 400;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = MAX_INTERVALS + 16;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  bit          calm = 1'b0;
  int          hold_reqs = 0;
  int          sent = 0;
  int          pick;
  int          phase_len;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] pool_lo [$];
  logic [31:0] pool_hi [$];

  smallest_covering_interval_query #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  scq_cover_checker #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) cover_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input in_item_t it);
    int          gap;
    logic [127:0] junk;
    gap = (calm || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      junk = {$urandom(), $urandom(), $urandom(), $urandom()};
      in_valid <= 1'b0;
      in_item  <= junk[$bits(in_item_t)-1:0];
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // sender pause: nothing offered until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_add(input logic [31:0] a, input logic [31:0] b);
    if (a <= b) begin
      pool_lo.push_back(a);
      pool_hi.push_back(b);
    end
    send('{MODE_ADD, a, b, $urandom()});
  endtask

  task automatic put_query(input logic [31:0] p);
    send('{MODE_QUERY, $urandom(), $urandom(), p});
  endtask

  task automatic put_clear();
    pool_lo.delete();
    pool_hi.delete();
    send('{MODE_CLEAR, $urandom(), $urandom(), $urandom()});
  endtask

  task automatic put_spare();
    send('{MODE_SPARE, $urandom(), $urandom(), $urandom()});
  endtask

  task automatic rand_interval(input bit allow_rev);
    int          r;
    logic [31:0] t;
    r = $urandom_range(0, allow_rev ? 99 : 91);
    if (r < 60) begin
      lo = $urandom_range(0, 400);
      hi = lo + $urandom_range(0, 60);
    end else if (r < 75) begin
      lo = $urandom_range(0, 400);
      hi = lo + $urandom_range(0, 100000);
    end else if (r < 85) begin
      lo = $urandom();
      hi = $urandom();
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end else if (r < 92) begin
      lo = $urandom_range(0, 3);
      hi = 32'hFFFF_FFFF - $urandom_range(0, 3);
    end else begin
      hi = $urandom_range(0, 400);
      lo = hi + $urandom_range(1, 50);
    end
  endtask

  // mostly points on or next to stored ends, the rest anywhere
  function automatic logic [31:0] rand_point();
    int k;
    if (pool_lo.size() == 0 || $urandom_range(0, 99) < 25) begin
      return ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 500);
    end
    k = $urandom_range(0, pool_lo.size() - 1);
    case ($urandom_range(0, 4))
      0: return pool_lo[k] - 1;
      1: return pool_lo[k];
      2: return pool_hi[k];
      3: return pool_hi[k] + 1;
      default: return pool_lo[k] + $urandom_range(0, pool_hi[k] - pool_lo[k]);
    endcase
  endfunction

  // receiver: random stalls, calm stretches and the long hold requested by the sender
  initial begin
    int run;
    int holds_done;
    run        = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        holds_done++;
        run = 4;
      end else if (run > 0) begin
        run--;
      end else if (calm) begin
        out_stall <= 1'b0;
        run = $urandom_range(8, 40);
      end else if ($urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        run = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(0, 8);
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_query(32'd7);
    put_spare();
    put_add(32'd0, 32'hFFFF_FFFF);
    put_query(32'd0);
    put_query(32'hFFFF_FFFF);
    put_add(32'hFFFF_FFFF, 32'd0);
    put_add(32'd100, 32'd100);
    put_query(32'd100);
    put_add(32'd90, 32'd120);
    put_add(32'd95, 32'd105);
    put_query(32'd99);
    put_query(32'd121);
    put_clear();
    put_query(32'd100);
    put_add(32'd5, 32'd5);
    put_query(32'd4);
    put_query(32'd6);
    put_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_query(32'hFFFF_FFFF);
    put_query(32'd0);

    // fill past capacity while the receiver holds off
    put_clear();
    calm      <= 1'b1;
    hold_reqs <= hold_reqs + 1;
    repeat (MAX_INTERVALS + 2) begin
      rand_interval(1'b0);
      put_add(lo, hi);
    end
    put_add(32'd9, 32'd3);
    put_query(rand_point());
    put_query(rand_point());
    drain();
    calm <= 1'b0;

    while (sent < ITEM_GOAL) begin
      calm <= ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 20) drain();
      if ($urandom_range(0, 99) < 70) put_clear();
      if ($urandom_range(0, 99) < 6) begin
        repeat (MAX_INTERVALS + $urandom_range(0, 3)) begin
          rand_interval(1'b0);
          put_add(lo, hi);
        end
      end
      phase_len = $urandom_range(4, 30);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          rand_interval(1'b1);
          put_add(lo, hi);
        end else if (pick < 94) begin
          put_query(rand_point());
        end else if (pick < 97) begin
          put_spare();
        end else begin
          put_clear();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
